// ----- rtl/core/stfl_pkg.sv -----
// shared types and constants for the slot table with free list
package stfl_pkg;

	localparam int DEF_CAPACITY = 256;

	typedef enum logic [2:0] {
		KIND_CREATE  = 3'd0,
		KIND_DESTROY = 3'd1,
		KIND_SET_POS = 3'd2,
		KIND_SET_VEL = 3'd3,
		KIND_SET_ST  = 3'd4,
		KIND_READ    = 3'd5,
		KIND_INTEG   = 3'd6,
		KIND_NONE    = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_CREATE,
		S_DES_LAST,
		S_DES_MOVE,
		S_READ,
		S_INT_ADDR,
		S_INT_RD,
		S_INT_X,
		S_INT_Y,
		S_INT_WR,
		S_DONE
	} fsm_t;

endpackage

// ----- rtl/core/stfl_advance.sv -----
// shared integration unit: position plus rounded velocity times dt, saturated
module stfl_advance (
	input  logic               clk,
	input  logic signed [31:0] p,
	input  logic signed [31:0] v,
	input  logic        [15:0] dt,
	output logic signed [31:0] res_q
);
	logic signed [48:0] prod;
	logic signed [48:0] prod_q;
	logic signed [31:0] p_q;
	logic signed [37:0] step;
	logic signed [38:0] sum;

	assign prod = v * $signed({1'b0, dt});
	always_ff @(posedge clk) begin
		prod_q <= prod;
		p_q <= p;
	end

	// round half up, then floor shift
	assign step = 38'((prod_q + 49'sd2048) >>> 12);
	assign sum = 39'(p_q) + 39'(step);

	always_comb begin
		if (sum > 39'sd2147483647)
			res_q = 32'h7fffffff;
		else if (sum < -39'sd2147483648)
			res_q = 32'h80000000;
		else
			res_q = sum[31:0];
	end
endmodule

// ----- rtl/core/slot_table_with_free_list.sv -----
// top level of the slot table with free list
// Fixed-capacity entity table. One request on the input channel (kind, slot,
// position, velocity, state word, dt) gives one response on the output channel.
// Create pops the free list or takes the next never-used slot; destroy moves
// the last dense entry into the hole and pushes the slot on the free list.
// Set, read and destroy of a slot not live give status bad-slot.
// A set, a bad slot or an unused kind goes from lookup straight to the
// response; create and read pass their own state, destroy a fetch of the
// last dense entry and a move; integrate steps through address, read, x, y
// and write per live entry, as x and y share one multiplier and each store
// has one read port. stall is high while a request is being worked on or
// a response waits; the next request is taken in the idle state that
// follows the response. A response held by stall on the output keeps the
// block from taking the next request. Reset clears live marks, free head,
// high water and the live count; stores need no clearing since only live
// slots are read. No clearing pass is needed after reset.
module slot_table_with_free_list #(
	parameter int CAPACITY = stfl_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         kind,
	input  logic [7:0]         slot,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic [31:0]        state_bits,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         result_slot,
	output logic [1:0]         status,
	output logic               is_alive,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_vel_x,
	output logic signed [31:0] out_vel_y,
	output logic [31:0]        out_state_bits,
	output logic [8:0]         live_count
);
	import stfl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [31:0] cx_mem [CAPACITY];
	logic signed [31:0] cy_mem [CAPACITY];
	logic signed [31:0] vx_mem [CAPACITY];
	logic signed [31:0] vy_mem [CAPACITY];
	logic [31:0]        sw_mem [CAPACITY];
	logic [AW-1:0]      dl_mem [CAPACITY];
	logic [AW-1:0]      dp_mem [CAPACITY];
	logic [CW-1:0]      fl_mem [CAPACITY];
	logic [CAPACITY-1:0] live_q;

	fsm_t state_q, state_d;
	logic [2:0]         kind_q;
	logic [7:0]         slot_q;
	logic signed [31:0] px_q, py_q, vx_q, vy_q;
	logic [31:0]        sb_q;
	logic [15:0]        dt_q;
	logic [CW-1:0]      head_q, hw_q, total_q, idx_q;
	logic [AW-1:0]      n_q, ent_q, last_q, hole_q;

	// registered read data
	logic signed [31:0] rcx_q, rcy_q, rvx_q, rvy_q;
	logic [31:0]        rsw_q;
	logic signed [31:0] ax_q;
	logic signed [31:0] adv_p, adv_v, adv_res;

	logic slot_ok;
	assign slot_ok = (CW'(slot_q) < hw_q) && (32'(slot_q) < CAPACITY)
		&& live_q[AW'(slot_q)];

	stfl_advance u_adv (
		.clk(clk), .p(adv_p), .v(adv_v), .dt(dt_q), .res_q(adv_res)
	);
	// x goes into the unit in S_INT_X, y in S_INT_Y
	assign adv_p = (state_q == S_INT_X) ? rcx_q : rcy_q;
	assign adv_v = (state_q == S_INT_X) ? rvx_q : rvy_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_valid) state_d = S_LOOK;
			S_LOOK: begin
				case (kind_q)
					KIND_CREATE:  state_d = S_CREATE;
					KIND_DESTROY: state_d = slot_ok ? S_DES_LAST : S_DONE;
					KIND_READ:    state_d = slot_ok ? S_READ : S_DONE;
					KIND_INTEG:   state_d = (total_q == '0) ? S_DONE : S_INT_ADDR;
					default:      state_d = S_DONE;
				endcase
			end
			S_CREATE:   state_d = S_DONE;
			S_DES_LAST: state_d = S_DES_MOVE;
			S_DES_MOVE: state_d = S_DONE;
			S_READ:     state_d = S_DONE;
			S_INT_ADDR: state_d = S_INT_RD;
			S_INT_RD:   state_d = S_INT_X;
			S_INT_X:    state_d = S_INT_Y;
			S_INT_Y:    state_d = S_INT_WR;
			S_INT_WR:   state_d = (idx_q + 1'b1 >= total_q) ? S_DONE : S_INT_ADDR;
			S_DONE:     if (!out_stall) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign out_valid = (state_q == S_DONE);
	assign live_count = 9'(total_q);

	function automatic logic [AW-1:0] n_sel();
		return (head_q < CW'(CAPACITY)) ? head_q[AW-1:0] : hw_q[AW-1:0];
	endfunction

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			head_q <= CW'(CAPACITY);
			hw_q <= '0;
			total_q <= '0;
		end else begin
			case (state_q)
				S_LOOK: begin
					if (kind_q == KIND_CREATE) begin
						if (head_q < CW'(CAPACITY)) begin
							head_q <= fl_mem[head_q[AW-1:0]];
						end else if (hw_q < CW'(CAPACITY)) begin
							hw_q <= hw_q + 1'b1;
						end
						if (head_q < CW'(CAPACITY) || hw_q < CW'(CAPACITY)) begin
							live_q[n_sel()] <= 1'b1;
							if (total_q < CW'(CAPACITY)) total_q <= total_q + 1'b1;
						end
					end else if (kind_q == KIND_DESTROY && slot_ok) begin
						live_q[AW'(slot_q)] <= 1'b0;
						head_q <= CW'(slot_q);
					end
				end
				S_DES_MOVE: if (total_q != '0) total_q <= total_q - 1'b1;
				default: ;
			endcase
		end
	end

	// datapath and memories
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q <= kind; slot_q <= slot;
				px_q <= pos_x; py_q <= pos_y; vx_q <= vel_x; vy_q <= vel_y;
				sb_q <= state_bits; dt_q <= time_step;
				idx_q <= '0;
				result_slot <= '0; status <= ST_OK; is_alive <= 1'b0;
				out_pos_x <= '0; out_pos_y <= '0; out_vel_x <= '0; out_vel_y <= '0;
				out_state_bits <= '0;
			end
			S_LOOK: begin
				n_q <= n_sel();
				hole_q <= dp_mem[AW'(slot_q)];
				rcx_q <= cx_mem[AW'(slot_q)]; rcy_q <= cy_mem[AW'(slot_q)];
				rvx_q <= vx_mem[AW'(slot_q)]; rvy_q <= vy_mem[AW'(slot_q)];
				rsw_q <= sw_mem[AW'(slot_q)];
				case (kind_q)
					KIND_CREATE: begin
						if (head_q >= CW'(CAPACITY) && hw_q >= CW'(CAPACITY))
							status <= ST_FULL;
						else begin
							if (head_q >= CW'(CAPACITY)) fl_mem[hw_q[AW-1:0]] <= CW'(CAPACITY);
						end
					end
					KIND_DESTROY, KIND_SET_POS, KIND_SET_VEL, KIND_SET_ST, KIND_READ: begin
						result_slot <= slot_q;
						if (!slot_ok) status <= ST_BAD;
						else begin
							if (kind_q != KIND_DESTROY) is_alive <= 1'b1;
							case (kind_q)
								KIND_DESTROY: fl_mem[AW'(slot_q)] <= head_q;
								KIND_SET_POS: begin
									cx_mem[AW'(slot_q)] <= px_q; cy_mem[AW'(slot_q)] <= py_q;
								end
								KIND_SET_VEL: begin
									vx_mem[AW'(slot_q)] <= vx_q; vy_mem[AW'(slot_q)] <= vy_q;
								end
								KIND_SET_ST: sw_mem[AW'(slot_q)] <= sb_q;
								default: ;
							endcase
						end
					end
					default: ;
				endcase
			end
			S_CREATE: begin
				if (status == ST_OK) begin
					cx_mem[n_q] <= px_q; cy_mem[n_q] <= py_q;
					vx_mem[n_q] <= vx_q; vy_mem[n_q] <= vy_q;
					sw_mem[n_q] <= sb_q;
					result_slot <= 8'(n_q);
					is_alive <= 1'b1;
					// total_q already counts this entry
					if (total_q <= CW'(CAPACITY) && total_q != '0) begin
						dp_mem[n_q] <= AW'(total_q - 1'b1);
						dl_mem[AW'(total_q - 1'b1)] <= n_q;
					end
				end
			end
			S_DES_LAST: last_q <= dl_mem[AW'(total_q - 1'b1)];
			S_DES_MOVE: begin
				dl_mem[hole_q] <= last_q;
				dp_mem[last_q] <= hole_q;
			end
			S_READ: begin
				out_pos_x <= rcx_q; out_pos_y <= rcy_q;
				out_vel_x <= rvx_q; out_vel_y <= rvy_q;
				out_state_bits <= rsw_q;
			end
			S_INT_ADDR: ent_q <= dl_mem[idx_q[AW-1:0]];
			S_INT_RD: begin
				rcx_q <= cx_mem[ent_q]; rcy_q <= cy_mem[ent_q];
				rvx_q <= vx_mem[ent_q]; rvy_q <= vy_mem[ent_q];
			end
			S_INT_Y: ax_q <= adv_res;
			S_INT_WR: begin
				cx_mem[ent_q] <= ax_q;
				cy_mem[ent_q] <= adv_res;
				idx_q <= idx_q + 1'b1;
			end
			default: ;
		endcase
	end
endmodule
